/* hw/rtl/imu_sfd_pkg.sv */
package imu_sfd_pkg;

  // Byte that opens every frame.
  localparam logic [7:0] HDR_BYTE = 8'h55;

  // Byte positions inside a frame; payload bytes sit between POS_TYPE and POS_SUM.
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_TYPE    = 4'd1;
  localparam logic [3:0] POS_PAYLOAD = 4'd2;
  localparam logic [3:0] POS_LAST    = 4'd9;
  localparam logic [3:0] POS_SUM     = 4'd10;

  // Configuration register indexes.
  localparam logic [2:0] REG_ACCEL_CODE = 3'd0;
  localparam logic [2:0] REG_GYRO_CODE  = 3'd1;
  localparam logic [2:0] REG_ANGLE_CODE = 3'd2;
  localparam logic [2:0] REG_ALT_CODE   = 3'd3;
  localparam logic [2:0] REG_CKS_EN     = 3'd4;

  // Scale coefficients in units of 2^-24 (product is shifted right by 8).
  localparam logic [16:0] COEFF_ACCEL = 17'd80282;
  localparam logic [16:0] COEFF_GYRO  = 17'd17872;
  localparam logic [16:0] COEFF_ANGLE = 17'd92160;

  localparam int VAL_W = 25;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_ALT   = 2'd3
  } kind_t;

  // Configuration seen by the parser.
  typedef struct packed {
    logic [7:0] accel_code;
    logic [7:0] gyro_code;
    logic [7:0] angle_code;
    logic [7:0] alt_code;
    logic       cks_en;
  } cfg_t;

  // One decoded frame ahead of scaling.
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic               ok;
  } frame_t;

  // Coefficient for a frame kind; angle and altitude share one.
  function automatic logic [16:0] coeff_of(kind_t kind);
    logic [16:0] c;
    unique case (kind)
      KIND_ACCEL: c = COEFF_ACCEL;
      KIND_GYRO:  c = COEFF_GYRO;
      default:    c = COEFF_ANGLE;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/imu_sfd_parser.sv */
module imu_sfd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imu_sfd_pkg::cfg_t    cfg_i,
  input  logic                 byte_v_i,
  input  logic [7:0]           byte_i,
  output logic                 byte_rdy_o,
  output logic                 frm_v_o,
  output imu_sfd_pkg::frame_t  frm_o,
  input  logic                 frm_rdy_i
);

  logic [3:0]          pos_r, pos_nxt;
  imu_sfd_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          store_r [8];
  logic                frm_v_r;
  imu_sfd_pkg::frame_t frm_r;
  logic                take;
  logic                emit;
  logic                ok;
  logic                wr_en;
  logic [2:0]          wr_idx;

  // The frame register takes a new frame when it is empty or being drained.
  assign byte_rdy_o = !frm_v_r || frm_rdy_i;
  assign take       = byte_v_i && byte_rdy_o;
  assign ok         = (sum_r == byte_i);
  assign wr_idx     = 3'(pos_r - imu_sfd_pkg::POS_PAYLOAD);

  // Frame position, kind and running sum.
  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    sum_nxt  = sum_r;
    emit     = 1'b0;
    wr_en    = 1'b0;
    if (take) begin
      priority if (pos_r == imu_sfd_pkg::POS_TYPE) begin
        pos_nxt = imu_sfd_pkg::POS_PAYLOAD;
        sum_nxt = sum_r + byte_i;
        priority if (byte_i == cfg_i.accel_code) begin
          kind_nxt = imu_sfd_pkg::KIND_ACCEL;
        end else if (byte_i == cfg_i.gyro_code) begin
          kind_nxt = imu_sfd_pkg::KIND_GYRO;
        end else if (byte_i == cfg_i.angle_code) begin
          kind_nxt = imu_sfd_pkg::KIND_ANGLE;
        end else if (byte_i == cfg_i.alt_code) begin
          kind_nxt = imu_sfd_pkg::KIND_ALT;
        end else begin
          // Unknown type: back to hunting, nothing else changes.
          pos_nxt = imu_sfd_pkg::POS_HUNT;
          sum_nxt = sum_r;
        end
      end else if (pos_r >= imu_sfd_pkg::POS_PAYLOAD && pos_r <= imu_sfd_pkg::POS_LAST) begin
        wr_en   = 1'b1;
        sum_nxt = sum_r + byte_i;
        pos_nxt = pos_r + 4'd1;
      end else if (pos_r == imu_sfd_pkg::POS_SUM) begin
        pos_nxt = imu_sfd_pkg::POS_HUNT;
        emit    = !(cfg_i.cks_en && !ok);
      end else begin
        // Hunting, including the unreachable position codes.
        if (byte_i == imu_sfd_pkg::HDR_BYTE) begin
          pos_nxt = imu_sfd_pkg::POS_TYPE;
          sum_nxt = imu_sfd_pkg::HDR_BYTE;
        end else begin
          pos_nxt = imu_sfd_pkg::POS_HUNT;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= imu_sfd_pkg::POS_HUNT;
      kind_r  <= imu_sfd_pkg::KIND_ACCEL;
      sum_r   <= '0;
      frm_v_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      sum_r  <= sum_nxt;
      if (emit) begin
        frm_v_r <= 1'b1;
      end else if (frm_rdy_i) begin
        frm_v_r <= 1'b0;
      end
    end
  end

  // Payload bytes and the captured frame.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= byte_i;
    end
    if (emit) begin
      frm_r.kind <= kind_r;
      frm_r.w0   <= {store_r[1], store_r[0]};
      frm_r.w1   <= {store_r[3], store_r[2]};
      frm_r.w2   <= {store_r[5], store_r[4]};
      frm_r.ok   <= ok;
    end
  end

  assign frm_v_o = frm_v_r;
  assign frm_o   = frm_r;

`ifndef ASSERT_OFF
  // The position never leaves the frame range once out of reset.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= imu_sfd_pkg::POS_SUM)
    else $error("byte position out of range");

  // A new frame only appears right after a sum byte was taken.
  a_frame_src: assert property (@(posedge clk) disable iff (!rst_n)
    (frm_v_r && !$past(frm_v_r)) |-> ($past(pos_r) == imu_sfd_pkg::POS_SUM && $past(take)))
    else $error("frame without sum byte");

  // With checking on, a frame that reaches the register has a good sum.
  a_cks_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (frm_v_r && !$past(frm_v_r) && $past(cfg_i.cks_en)) |-> frm_r.ok)
    else $error("bad-sum frame passed with checking on");
`endif

endmodule

/* hw/rtl/imu_sfd_scaler.sv */
module imu_sfd_scaler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 frm_v_i,
  input  imu_sfd_pkg::frame_t  frm_i,
  output logic                 frm_rdy_o,
  output logic                 out_v_o,
  output logic [79:0]          out_data_o,
  output logic [2:0]           out_user_o,
  input  logic                 out_rdy_i
);

  localparam int VW = imu_sfd_pkg::VAL_W;

  logic                 out_v_r;
  logic [VW-1:0]        x_r, y_r, z_r;
  imu_sfd_pkg::kind_t   kind_r;
  logic                 ok_r;
  logic                 load;
  logic signed [17:0]   coeff;
  logic signed [33:0]   px, py, pz;
  logic [VW-1:0]        x_nxt, y_nxt, z_nxt;

  assign frm_rdy_o = !out_v_r || out_rdy_i;
  assign load      = frm_v_i && frm_rdy_o;

  // Signed multiply, then floor shift by 8 bits down to Q8.16.
  assign coeff = $signed({1'b0, imu_sfd_pkg::coeff_of(frm_i.kind)});
  assign px    = frm_i.w0 * coeff;
  assign py    = frm_i.w1 * coeff;
  assign pz    = frm_i.w2 * coeff;
  assign x_nxt = px[VW+7:8];
  assign y_nxt = py[VW+7:8];
  assign z_nxt = (frm_i.kind == imu_sfd_pkg::KIND_ALT) ? '0 : pz[VW+7:8];

  // Result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_rdy_i) begin
      out_v_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      kind_r <= frm_i.kind;
      ok_r   <= frm_i.ok;
    end
  end

  assign out_v_o    = out_v_r;
  assign out_data_o = {5'd0, z_r, y_r, x_r};
  assign out_user_o = {ok_r, kind_r};

endmodule

/* hw/rtl/imu_serial_frame_decoder.sv */
// Serial frame decoder for a 0x55-framed inertial sensor byte stream.
// Throughput: one received byte per clock cycle, sustained while the result stream is not back-pressured.
// After its sum byte is accepted, a result passes from the input register
// through the frame register to the scaled result register.
// Reset (rst_n low, synchronous) returns to header hunting, empties every
// stage and loads the default type codes with sum checking off.
module imu_serial_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: tdata[7:0] rx_byte.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result stream: tdata[24:0] value_x, [49:25] value_y, [74:50] value_z, rest zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  // Result tuser: [1:0] frame_kind, [2] checksum_ok.
  output logic [2:0]  out_tuser,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  imu_sfd_pkg::cfg_t   cfg_r;
  logic                byte_v_r;
  logic [7:0]          byte_r;
  logic                parse_rdy;
  logic                frm_v;
  imu_sfd_pkg::frame_t frm;
  logic                frm_rdy;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_code <= 8'd81;
      cfg_r.gyro_code  <= 8'd82;
      cfg_r.angle_code <= 8'd83;
      cfg_r.alt_code   <= 8'd86;
      cfg_r.cks_en     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        imu_sfd_pkg::REG_ACCEL_CODE: cfg_r.accel_code <= cfg_data;
        imu_sfd_pkg::REG_GYRO_CODE:  cfg_r.gyro_code  <= cfg_data;
        imu_sfd_pkg::REG_ANGLE_CODE: cfg_r.angle_code <= cfg_data;
        imu_sfd_pkg::REG_ALT_CODE:   cfg_r.alt_code   <= cfg_data;
        imu_sfd_pkg::REG_CKS_EN:     cfg_r.cks_en     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register; refilled whenever the parser takes its byte.
  assign in_tready = !byte_v_r || parse_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else if (in_tready) begin
      byte_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  imu_sfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .byte_v_i   (byte_v_r),
    .byte_i     (byte_r),
    .byte_rdy_o (parse_rdy),
    .frm_v_o    (frm_v),
    .frm_o      (frm),
    .frm_rdy_i  (frm_rdy)
  );

  imu_sfd_scaler u_scaler (
    .clk        (clk),
    .rst_n      (rst_n),
    .frm_v_i    (frm_v),
    .frm_i      (frm),
    .frm_rdy_o  (frm_rdy),
    .out_v_o    (out_tvalid),
    .out_data_o (out_tdata),
    .out_user_o (out_tuser),
    .out_rdy_i  (out_tready)
  );

endmodule
